[rtl/sme_pkg.sv]
package sme_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int HEAP_CELLS  = 1024;
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = SAW + 1;
  localparam int HAW = $clog2(HEAP_CELLS);
  localparam int HCW = HAW + 1;

  localparam logic [5:0] OP_HALT  = 6'h00;
  localparam logic [5:0] OP_JUMP  = 6'h01;
  localparam logic [5:0] OP_JNZ   = 6'h02;
  localparam logic [5:0] OP_DUP   = 6'h03;
  localparam logic [5:0] OP_DROP  = 6'h04;
  localparam logic [5:0] OP_PUSH4 = 6'h05;
  localparam logic [5:0] OP_PUSH2 = 6'h06;
  localparam logic [5:0] OP_PUSH1 = 6'h07;
  localparam logic [5:0] OP_ADD   = 6'h08;
  localparam logic [5:0] OP_SUB   = 6'h09;
  localparam logic [5:0] OP_MUL   = 6'h0a;
  localparam logic [5:0] OP_DIV   = 6'h0b;
  localparam logic [5:0] OP_MOD   = 6'h0c;
  localparam logic [5:0] OP_EQ    = 6'h0d;
  localparam logic [5:0] OP_NE    = 6'h0e;
  localparam logic [5:0] OP_LT    = 6'h0f;
  localparam logic [5:0] OP_GT    = 6'h10;
  localparam logic [5:0] OP_LE    = 6'h11;
  localparam logic [5:0] OP_GE    = 6'h12;
  localparam logic [5:0] OP_NOT   = 6'h13;
  localparam logic [5:0] OP_AND   = 6'h14;
  localparam logic [5:0] OP_OR    = 6'h15;
  localparam logic [5:0] OP_IN    = 6'h16;
  localparam logic [5:0] OP_OUT   = 6'h17;
  localparam logic [5:0] OP_CLOCK = 6'h2a;
  localparam logic [5:0] OP_CONS  = 6'h2b;
  localparam logic [5:0] OP_HD    = 6'h2c;
  localparam logic [5:0] OP_TL    = 6'h2d;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_UNDER   = 3'd1;
  localparam logic [2:0] ERR_OVER    = 3'd2;
  localparam logic [2:0] ERR_DIVZERO = 3'd3;
  localparam logic [2:0] ERR_HEAP    = 3'd4;
  localparam logic [2:0] ERR_NOTCELL = 3'd5;
  localparam logic [2:0] ERR_OPCODE  = 3'd6;

  typedef enum logic [3:0] {
    CL_HALT, CL_JUMP, CL_JNZ, CL_DUP, CL_DROP, CL_PUSH, CL_ALU, CL_DIV,
    CL_EQ, CL_NOT, CL_LOGIC, CL_OUT, CL_CLK, CL_CONS, CL_HDTL, CL_BAD
  } cls_t;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIV, ST_HEAP} state_t;

  typedef struct packed {
    logic [5:0]  op;
    cls_t        cls;
    logic [31:0] value;
    logic [2:0]  len;
  } item_t;

endpackage

[rtl/stack_machine_execute_unit_top.sv]
// Bytecode execute unit: each request carries one opcode with its four
// little-endian operand bytes and an input character, and yields one result
// with the next fetch address, an optional output character, a clock request,
// the halt flag and a sticky error code. Once halted, by the halt opcode or by
// any error, every later request simply reports the stopped state until reset.
// A request passes through a registered read of the stack entries it needs (the
// two topmost, or for dup the entry it names) and a commit; head and tail add
// an extra heap read, and div and mod wait for the one-bit-per-cycle divider.
// Once stopped, a request finishes without an execute step. A two-entry queue in
// front lets requests arrive while one executes. A request leaves the queue
// only when the result register is free or its result is taken in the same
// cycle, so a result that waits stalls the execute stage.
module stack_machine_execute_unit_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [5:0]        in_kind,
  input  logic [31:0]       in_immediate,
  input  logic signed [8:0] in_input_char,
  output logic              empty,
  input  logic              pop,
  output logic [15:0]       out_next_pc,
  output logic              out_out_valid,
  output logic [7:0]        out_out_char,
  output logic              out_clock_request,
  output logic              out_halted,
  output logic [2:0]        out_error_code
);

  // Decoded requests travel from the front queue to the execute stage.
  logic           q_valid;
  logic           q_pop;
  sme_pkg::item_t q_item;

  // The front end classifies opcodes and sign-extends literals.
  sme_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_kind       (in_kind),
    .in_immediate  (in_immediate),
    .in_input_char (in_input_char),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // The back end owns the stack, the heap, the counters and the result register.
  sme_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .empty             (empty),
    .pop               (pop),
    .out_next_pc       (out_next_pc),
    .out_out_valid     (out_out_valid),
    .out_out_char      (out_out_char),
    .out_clock_request (out_clock_request),
    .out_halted        (out_halted),
    .out_error_code    (out_error_code)
  );

endmodule

[rtl/sme_front.sv]
module sme_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [5:0]        in_kind,
  input  logic [31:0]       in_immediate,
  input  logic signed [8:0] in_input_char,
  output logic              q_valid,
  output sme_pkg::item_t    q_item,
  input  logic              q_pop
);

  sme_pkg::item_t fifo_r [2];
  logic           wptr_r, rptr_r;
  logic [1:0]     cnt_r;
  sme_pkg::item_t dec;
  logic           wr_en;

  // Classify the opcode and pre-extend any literal that will be pushed.
  always_comb begin
    dec.op    = in_kind;
    dec.cls   = sme_pkg::CL_BAD;
    dec.value = in_immediate;
    dec.len   = 3'd1;
    unique case (in_kind)
      sme_pkg::OP_HALT: begin
        dec.cls = sme_pkg::CL_HALT;
        dec.len = 3'd0;
      end
      sme_pkg::OP_JUMP: begin
        dec.cls = sme_pkg::CL_JUMP;
        dec.len = 3'd0;
      end
      sme_pkg::OP_JNZ: begin
        dec.cls = sme_pkg::CL_JNZ;
        dec.len = 3'd3;
      end
      sme_pkg::OP_DUP: begin
        dec.cls = sme_pkg::CL_DUP;
        dec.len = 3'd2;
      end
      sme_pkg::OP_DROP: dec.cls = sme_pkg::CL_DROP;
      sme_pkg::OP_PUSH4: begin
        dec.cls = sme_pkg::CL_PUSH;
        dec.len = 3'd5;
      end
      sme_pkg::OP_PUSH2: begin
        dec.cls   = sme_pkg::CL_PUSH;
        dec.len   = 3'd3;
        dec.value = {{16{in_immediate[15]}}, in_immediate[15:0]};
      end
      sme_pkg::OP_PUSH1: begin
        dec.cls   = sme_pkg::CL_PUSH;
        dec.len   = 3'd2;
        dec.value = {{24{in_immediate[7]}}, in_immediate[7:0]};
      end
      sme_pkg::OP_IN: begin
        dec.cls   = sme_pkg::CL_PUSH;
        dec.value = {{23{in_input_char[8]}}, in_input_char};
      end
      sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_LT,
      sme_pkg::OP_GT, sme_pkg::OP_LE, sme_pkg::OP_GE: dec.cls = sme_pkg::CL_ALU;
      sme_pkg::OP_DIV, sme_pkg::OP_MOD: dec.cls = sme_pkg::CL_DIV;
      sme_pkg::OP_EQ, sme_pkg::OP_NE:   dec.cls = sme_pkg::CL_EQ;
      sme_pkg::OP_NOT:                  dec.cls = sme_pkg::CL_NOT;
      sme_pkg::OP_AND, sme_pkg::OP_OR:  dec.cls = sme_pkg::CL_LOGIC;
      sme_pkg::OP_OUT:                  dec.cls = sme_pkg::CL_OUT;
      sme_pkg::OP_CLOCK:                dec.cls = sme_pkg::CL_CLK;
      sme_pkg::OP_CONS:                 dec.cls = sme_pkg::CL_CONS;
      sme_pkg::OP_HD, sme_pkg::OP_TL:   dec.cls = sme_pkg::CL_HDTL;
      default:                          dec.cls = sme_pkg::CL_BAD;
    endcase
  end

  assign full    = (cnt_r == 2'd2);
  assign wr_en   = push && !full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = fifo_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_r[wptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en) wptr_r <= !wptr_r;
      if (q_pop) rptr_r <= !rptr_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, q_pop};
    end
  end

endmodule

[rtl/sme_div.sv]
module sme_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        is_mod,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] res
);

  logic        busy_r, done_r, negq_r, negr_r, mod_r;
  logic [4:0]  cnt_r;
  logic [31:0] quo_r, rem_r, dvs_r;
  logic [32:0] trial, diff;

  assign trial = {rem_r, quo_r[31]};
  assign diff  = trial - {1'b0, dvs_r};
  assign done  = done_r;
  assign res   = mod_r ? (negr_r ? 32'(-rem_r) : rem_r)
                       : (negq_r ? 32'(-quo_r) : quo_r);

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= a[31] ? 32'(-a) : a;
      dvs_r  <= b[31] ? 32'(-b) : b;
      rem_r  <= '0;
      negq_r <= a[31] ^ b[31];
      negr_r <= a[31];
      mod_r  <= is_mod;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= trial[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) busy_r <= 1'b0;
      end
    end
  end

endmodule

[rtl/sme_back.sv]
module sme_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  sme_pkg::item_t q_item,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [15:0]    out_next_pc,
  output logic           out_out_valid,
  output logic [7:0]     out_out_char,
  output logic           out_clock_request,
  output logic           out_halted,
  output logic [2:0]     out_error_code
);

  sme_pkg::state_t state_r, state_nxt;
  sme_pkg::item_t  it_r;
  logic [sme_pkg::SCW-1:0] cnt_r;
  logic [sme_pkg::HCW-1:0] cells_r;
  logic [15:0] pc_r;
  logic        stopped_r;
  logic [2:0]  err_r;

  logic [32:0] stk [sme_pkg::STACK_DEPTH];
  logic [32:0] heads [sme_pkg::HEAP_CELLS];
  logic [32:0] tails [sme_pkg::HEAP_CELLS];
  logic [32:0] rd0_r, rd1_r, hrd_r;
  logic [sme_pkg::SAW-1:0] ra0, ra1, wa;
  logic [sme_pkg::SCW-1:0] ra0_full, ra1_full, cnt_pop;

  logic        empty_r;
  logic [15:0] opc_r;
  logic        oval_r, ock_r, ohalt_r;
  logic [7:0]  och_r;
  logic [2:0]  oerr_r;

  logic        fin, go_div, go_heap, push_v, cons_v, stop_v;
  logic [1:0]  pops_v;
  logic [2:0]  e_v;
  logic [32:0] pushed_v;
  logic [15:0] npc_v;
  logic        ov_v, ck_v;
  logic [7:0]  oc_v;
  logic        div_done;
  logic [31:0] div_res, a, b;
  logic        t0, t1, less_ab, less_ba, need1, need2;

  sme_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (go_div),
    .is_mod (it_r.op == sme_pkg::OP_MOD),
    .a      (a),
    .b      (b),
    .done   (div_done),
    .res    (div_res)
  );

  assign ra0_full = cnt_r - sme_pkg::SCW'(1) -
                    ((q_item.cls == sme_pkg::CL_DUP) ? sme_pkg::SCW'(q_item.value[7:0])
                                                     : '0);
  assign ra1_full = cnt_r - sme_pkg::SCW'(2);
  assign ra0      = ra0_full[sme_pkg::SAW-1:0];
  assign ra1      = ra1_full[sme_pkg::SAW-1:0];
  assign cnt_pop  = cnt_r - sme_pkg::SCW'(pops_v);
  assign wa       = cnt_pop[sme_pkg::SAW-1:0];

  assign a       = rd1_r[31:0];
  assign b       = rd0_r[31:0];
  assign t0      = rd0_r[32] || (rd0_r[31:0] != 32'd0);
  assign t1      = rd1_r[32] || (rd1_r[31:0] != 32'd0);
  assign less_ab = $signed(a) < $signed(b);
  assign less_ba = $signed(b) < $signed(a);
  assign need1   = (cnt_r < sme_pkg::SCW'(1));
  assign need2   = (cnt_r < sme_pkg::SCW'(2));

  assign q_pop = (state_r == sme_pkg::ST_IDLE) && q_valid && (empty_r || pop);

  always_comb begin
    state_nxt = state_r;
    fin       = 1'b0;
    go_div    = 1'b0;
    go_heap   = 1'b0;
    push_v    = 1'b0;
    cons_v    = 1'b0;
    stop_v    = 1'b0;
    pops_v    = 2'd0;
    e_v       = sme_pkg::ERR_NONE;
    pushed_v  = {1'b0, it_r.value};
    npc_v     = pc_r + 16'(it_r.len);
    ov_v      = 1'b0;
    ck_v      = 1'b0;
    oc_v      = 8'd0;
    unique case (state_r)
      sme_pkg::ST_IDLE: begin
        if (q_pop) begin
          if (stopped_r) fin = 1'b1;
          else state_nxt = sme_pkg::ST_EXEC;
        end
      end
      sme_pkg::ST_EXEC: begin
        fin = 1'b1;
        unique case (it_r.cls)
          sme_pkg::CL_HALT: stop_v = 1'b1;
          sme_pkg::CL_JUMP: npc_v = it_r.value[15:0];
          sme_pkg::CL_JNZ: begin
            if (need1) e_v = sme_pkg::ERR_UNDER;
            pops_v = 2'd1;
            if (t0) npc_v = it_r.value[15:0];
          end
          sme_pkg::CL_DUP: begin
            if (32'(it_r.value[7:0]) >= 32'(cnt_r)) e_v = sme_pkg::ERR_UNDER;
            push_v   = 1'b1;
            pushed_v = rd0_r;
          end
          sme_pkg::CL_DROP: begin
            if (need1) e_v = sme_pkg::ERR_UNDER;
            pops_v = 2'd1;
          end
          sme_pkg::CL_PUSH: push_v = 1'b1;
          sme_pkg::CL_ALU: begin
            if (need2) e_v = sme_pkg::ERR_UNDER;
            pops_v = 2'd2;
            push_v = 1'b1;
            unique case (it_r.op)
              sme_pkg::OP_ADD: pushed_v = {1'b0, a + b};
              sme_pkg::OP_SUB: pushed_v = {1'b0, a - b};
              sme_pkg::OP_MUL: pushed_v = {1'b0, 32'(a * b)};
              sme_pkg::OP_LT:  pushed_v = 33'(less_ab);
              sme_pkg::OP_GT:  pushed_v = 33'(less_ba);
              sme_pkg::OP_LE:  pushed_v = 33'(!less_ba);
              default:         pushed_v = 33'(!less_ab);
            endcase
          end
          sme_pkg::CL_DIV: begin
            if (need2) e_v = sme_pkg::ERR_UNDER;
            else if (b == 32'd0) e_v = sme_pkg::ERR_DIVZERO;
            else begin
              fin       = 1'b0;
              go_div    = 1'b1;
              state_nxt = sme_pkg::ST_DIV;
            end
          end
          sme_pkg::CL_EQ: begin
            if (need2) e_v = sme_pkg::ERR_UNDER;
            pops_v   = 2'd2;
            push_v   = 1'b1;
            pushed_v = 33'((it_r.op == sme_pkg::OP_EQ) == (rd0_r == rd1_r));
          end
          sme_pkg::CL_NOT: begin
            if (need1) e_v = sme_pkg::ERR_UNDER;
            pops_v   = 2'd1;
            push_v   = 1'b1;
            pushed_v = 33'(!t0);
          end
          sme_pkg::CL_LOGIC: begin
            if (need2) e_v = sme_pkg::ERR_UNDER;
            pops_v   = 2'd2;
            push_v   = 1'b1;
            pushed_v = (it_r.op == sme_pkg::OP_AND) ? 33'(t0 && t1) : 33'(t0 || t1);
          end
          sme_pkg::CL_OUT: begin
            if (need1) e_v = sme_pkg::ERR_UNDER;
            pops_v = 2'd1;
            ov_v   = 1'b1;
            oc_v   = rd0_r[7:0];
          end
          sme_pkg::CL_CLK: ck_v = 1'b1;
          sme_pkg::CL_CONS: begin
            if (need2) e_v = sme_pkg::ERR_UNDER;
            else if (cells_r >= sme_pkg::HCW'(sme_pkg::HEAP_CELLS)) e_v = sme_pkg::ERR_HEAP;
            pops_v   = 2'd2;
            push_v   = 1'b1;
            cons_v   = 1'b1;
            pushed_v = {1'b1, 32'(cells_r)};
          end
          sme_pkg::CL_HDTL: begin
            if (need1) e_v = sme_pkg::ERR_UNDER;
            else if (!rd0_r[32] || rd0_r[31:0] >= 32'(cells_r)) e_v = sme_pkg::ERR_NOTCELL;
            else begin
              fin       = 1'b0;
              go_heap   = 1'b1;
              state_nxt = sme_pkg::ST_HEAP;
            end
          end
          default: e_v = sme_pkg::ERR_OPCODE;
        endcase
        if (e_v == sme_pkg::ERR_NONE && push_v &&
            cnt_pop >= sme_pkg::SCW'(sme_pkg::STACK_DEPTH)) begin
          e_v = sme_pkg::ERR_OVER;
        end
        if (fin) state_nxt = sme_pkg::ST_IDLE;
      end
      sme_pkg::ST_DIV: begin
        pops_v   = 2'd2;
        push_v   = 1'b1;
        pushed_v = {1'b0, div_res};
        if (div_done) begin
          fin       = 1'b1;
          state_nxt = sme_pkg::ST_IDLE;
        end
      end
      sme_pkg::ST_HEAP: begin
        fin       = 1'b1;
        pops_v    = 2'd1;
        push_v    = 1'b1;
        pushed_v  = hrd_r;
        state_nxt = sme_pkg::ST_IDLE;
      end
      default: state_nxt = sme_pkg::ST_IDLE;
    endcase
    if (stopped_r || e_v != sme_pkg::ERR_NONE || stop_v) npc_v = pc_r;
  end

  // Memories: registered reads, writes at the commit of an instruction.
  always_ff @(posedge clk) begin
    rd0_r <= stk[ra0];
    rd1_r <= stk[ra1];
    if (fin && !stopped_r && e_v == sme_pkg::ERR_NONE && push_v) begin
      stk[wa] <= pushed_v;
    end
  end

  always_ff @(posedge clk) begin
    if (go_heap) begin
      hrd_r <= (it_r.op == sme_pkg::OP_HD) ? heads[rd0_r[sme_pkg::HAW-1:0]]
                                            : tails[rd0_r[sme_pkg::HAW-1:0]];
    end
    if (fin && cons_v && e_v == sme_pkg::ERR_NONE) begin
      heads[cells_r[sme_pkg::HAW-1:0]] <= rd1_r;
      tails[cells_r[sme_pkg::HAW-1:0]] <= rd0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) it_r <= q_item;
    if (fin) begin
      opc_r   <= npc_v;
      oval_r  <= ov_v && !stopped_r && e_v == sme_pkg::ERR_NONE;
      och_r   <= (stopped_r || e_v != sme_pkg::ERR_NONE) ? 8'd0 : oc_v;
      ock_r   <= ck_v && !stopped_r && e_v == sme_pkg::ERR_NONE;
      ohalt_r <= stopped_r || stop_v || e_v != sme_pkg::ERR_NONE;
      oerr_r  <= stopped_r ? err_r : e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sme_pkg::ST_IDLE;
      cnt_r     <= '0;
      cells_r   <= '0;
      pc_r      <= '0;
      stopped_r <= 1'b0;
      err_r     <= sme_pkg::ERR_NONE;
      empty_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (fin) empty_r <= 1'b0;
      else if (pop) empty_r <= 1'b1;
      if (fin && !stopped_r) begin
        pc_r <= npc_v;
        if (e_v != sme_pkg::ERR_NONE) begin
          stopped_r <= 1'b1;
          err_r     <= e_v;
        end else begin
          if (stop_v) stopped_r <= 1'b1;
          cnt_r <= cnt_pop + sme_pkg::SCW'(push_v);
          if (cons_v) cells_r <= cells_r + sme_pkg::HCW'(1);
        end
      end
    end
  end

  assign empty             = empty_r;
  assign out_next_pc       = opc_r;
  assign out_out_valid     = oval_r;
  assign out_out_char      = och_r;
  assign out_clock_request = ock_r;
  assign out_halted        = ohalt_r;
  assign out_error_code    = oerr_r;

endmodule
